// File: src/ehf_pkg.sv
// Shared types and codes for the event hand-off FIFO.
// No dependencies; imported by every module of the block.
package ehf_pkg;

   localparam int DefQueueDepth = 16;
   localparam int DefDataWidth  = 32;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [2:0] ST_DELIVERED = 3'd0;
   localparam logic [2:0] ST_QUEUED    = 3'd1;
   localparam logic [2:0] ST_DROPPED   = 3'd2;
   localparam logic [2:0] ST_IGNORED   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [31:0] event_data;
   } req_type;

   typedef struct packed {
      logic        delivered;
      logic [31:0] delivered_data;
      logic [2:0]  status;
      logic [4:0]  queue_level;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the queue.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

// File: src/event_handoff_fifo.sv
// Event hand-off FIFO: producer pushes and consumer pulls share one request channel.
// The response is valid in the cycle after a request is accepted; one transaction
// per cycle while not stalled, set by the cell row shift and the one response register.
// Reset (synchronous, active high) empties the queue, clears consumer ready and disables
// events; stored words are not cleared, since a cell is only read once it has been filled.
// Depends on ehf_pkg and ehf_chain.
module event_handoff_fifo import ehf_pkg::*; #(
   parameter int QUEUE_DEPTH = DefQueueDepth,
   parameter int DATA_WIDTH  = DefDataWidth
) (
   input  logic    clock,
   input  logic    reset,
   // configuration: event_enable
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // the ports carry 32 bits, so no more than that is ever kept
   localparam int WordWidth  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(QUEUE_DEPTH);

   logic                   enable_ff;
   logic                   ready_ff, ready_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   is_push;
   logic [WordWidth-1:0]   push_word;
   logic [WordWidth-1:0]   head_word;
   logic [QUEUE_DEPTH-1:0] cell_full;
   cell_ctrl_type          cell_ctrl;

   // Configuration: always ready; the user must write it only while idle, not enforced here
   assign csr_ready = 1'b1;

   // Take a new transaction whenever the response register is free or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_push   = (req_data.cmd == CMD_PUSH);
   assign push_word = req_data.event_data[WordWidth-1:0];

   // Decide the transaction's outcome and the queue command
   always_comb begin
      ready_in       = ready_ff;
      count_in       = count_ff;
      cell_ctrl.push = 1'b0;
      cell_ctrl.pop  = 1'b0;
      rsp_in.delivered      = 1'b0;
      rsp_in.delivered_data = '0;
      rsp_in.status         = ST_EMPTY;

      if (is_push) begin
         if (!enable_ff) begin
            rsp_in.status = ST_IGNORED;
         end else if (count_ff == '0 && ready_ff) begin
            // bypass: hand straight to the waiting consumer
            ready_in              = 1'b0;
            rsp_in.delivered      = 1'b1;
            rsp_in.delivered_data = 32'(push_word);
            rsp_in.status         = ST_DELIVERED;
         end else if (count_ff == CountMax) begin
            rsp_in.status = ST_DROPPED;
         end else begin
            cell_ctrl.push = accept;
            count_in       = count_ff + 1'b1;
            rsp_in.status  = ST_QUEUED;
         end
      end else begin
         ready_in = 1'b1;
         if (count_ff != '0) begin
            // pop the oldest word from the head cell
            cell_ctrl.pop         = accept;
            count_in              = count_ff - 1'b1;
            rsp_in.delivered      = 1'b1;
            rsp_in.delivered_data = 32'(head_word);
            rsp_in.status         = ST_DELIVERED;
         end else begin
            rsp_in.status = ST_EMPTY;
         end
      end

      rsp_in.queue_level = 5'(count_in);
   end

   // Advance the response register: load on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
         if (accept) begin
            ready_ff <= ready_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload while the response waits
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   ehf_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORD_WIDTH  (WordWidth)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cell_ctrl),
      .push_word (push_word),
      .head_word (head_word),
      .cell_full (cell_full)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The occupied cells and the event count agree
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_full) == 32'(count_ff))
      else $error("cell occupancy disagrees with event count");

   // Never hold more events than cells
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountMax)
      else $error("event count beyond queue depth");

   // A push and a pop never reach the cells together
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cell_ctrl.push && cell_ctrl.pop))
      else $error("push and pop issued in the same cycle");

   // A bypassed push consumes the consumer's ready flag
   a_bypass_clears_ready: assert property (@(posedge clock) disable iff (reset)
      accept && is_push && enable_ff && count_ff == '0 && ready_ff |=> !ready_ff)
      else $error("consumer ready not cleared after bypass");

   // A pull always leaves the consumer marked ready and a response valid
   a_pull_sets_ready: assert property (@(posedge clock) disable iff (reset)
      accept && !is_push |=> ready_ff && rsp_valid_ff)
      else $error("pull did not set consumer ready");

endmodule

// File: src/ehf_cell.sv
// One queue cell: holds a word and an occupied flag, shifts towards the head on a pop.
// Depends on ehf_pkg.
module ehf_cell import ehf_pkg::*; #(
   parameter int WORD_WIDTH = DefDataWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [WORD_WIDTH-1:0] push_word,
   input  logic                  prev_full,
   input  logic [WORD_WIDTH-1:0] next_word,
   input  logic                  next_full,
   output logic [WORD_WIDTH-1:0] word,
   output logic                  full
);

   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  full_ff, full_in;
   logic                  load;

   // the first free cell behind an occupied one takes the pushed word
   assign load = ctrl.push && prev_full && !full_ff;

   always_comb begin
      word_in = word_ff;
      full_in = full_ff;
      if (ctrl.pop) begin
         word_in = next_word;
         full_in = next_full;
      end else if (load) begin
         word_in = push_word;
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign full = full_ff;

endmodule

// File: src/ehf_chain.sv
// Row of queue cells, oldest word in cell 0.
// Depends on ehf_pkg and ehf_cell.
module ehf_chain import ehf_pkg::*; #(
   parameter int QUEUE_DEPTH = DefQueueDepth,
   parameter int WORD_WIDTH  = DefDataWidth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [WORD_WIDTH-1:0]  push_word,
   output logic [WORD_WIDTH-1:0]  head_word,
   output logic [QUEUE_DEPTH-1:0] cell_full
);

   logic [WORD_WIDTH-1:0] word_w [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH:0]  full_w;

   // beyond the tail: an empty cell
   assign word_w[QUEUE_DEPTH] = '0;
   assign full_w[QUEUE_DEPTH] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic prev_full;
      if (i == 0) begin : g_head
         assign prev_full = 1'b1;
      end else begin : g_body
         assign prev_full = full_w[i-1];
      end

      ehf_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .push_word (push_word),
         .prev_full (prev_full),
         .next_word (word_w[i+1]),
         .next_full (full_w[i+1]),
         .word      (word_w[i]),
         .full      (full_w[i])
      );
   end

   assign head_word = word_w[0];
   assign cell_full = full_w[QUEUE_DEPTH-1:0];

endmodule
